FILE: hw/rtl/gs1_ai_element_splitter_assert.svh
// Assertion macros shared by the element splitter RTL.
`ifndef GS1_AI_ELEMENT_SPLITTER_ASSERT_SVH
`define GS1_AI_ELEMENT_SPLITTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GS1AI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GS1AI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gs1ai_pkg.sv
// Shared types and codes of the GS1 element splitter.
package gs1ai_pkg;

	localparam logic [7:0] GS_CHAR = 8'h1D;

	localparam int unsigned NUM_SLOTS = 3;

	localparam logic [1:0] EVK_OPEN  = 2'd0;
	localparam logic [1:0] EVK_VALUE = 2'd1;
	localparam logic [1:0] EVK_END   = 2'd2;

	// Identifier codes as carried in ai_code.
	localparam logic [2:0] AI_00 = 3'd0;
	localparam logic [2:0] AI_01 = 3'd1;
	localparam logic [2:0] AI_02 = 3'd2;
	localparam logic [2:0] AI_10 = 3'd3;
	localparam logic [2:0] AI_11 = 3'd4;
	localparam logic [2:0] AI_15 = 3'd5;
	localparam logic [2:0] AI_17 = 3'd6;
	localparam logic [2:0] AI_21 = 3'd7;

	typedef struct packed {
		logic [7:0] char_in;
		logic       first_char;
		logic       last_char;
		logic       strict_mode;
	} char_item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [2:0] ai_code;
		logic [7:0] value_char;
		logic       stopped_early;
		logic       last;
	} evt_item_t;

	// Events caused by one character, packed from slot 0, cnt of them valid.
	typedef struct packed {
		evt_item_t [NUM_SLOTS-1:0] ev;
		logic [1:0]                cnt;
	} evt_bundle_t;

endpackage

FILE: hw/rtl/gs1ai_parser.sv
// Per-string parse state and the single-pass next-state and event logic.
module gs1ai_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gs1ai_pkg::char_item_t   item,
	input  logic                    advance,
	output gs1ai_pkg::evt_bundle_t  bundle
);

	localparam logic [2:0] PH_AI1   = 3'd0;
	localparam logic [2:0] PH_AI2   = 3'd1;
	localparam logic [2:0] PH_FIXED = 3'd2;
	localparam logic [2:0] PH_VAR   = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	typedef struct packed {
		logic [2:0] phase;
		logic [4:0] remaining;
		logic [7:0] held_char;
		logic       held_valid;
		logic       held_first;
		logic [2:0] current_ai;
		logic [7:0] seen;
		logic       mode;
		logic       halted;
	} st_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] code;
	} ai_match_t;

	function automatic ai_match_t lookup_ai(input logic [7:0] a, input logic [7:0] b);
		ai_match_t m;
		m.hit  = 1'b1;
		m.code = gs1ai_pkg::AI_00;
		case ({a, b})
			16'h3030: m.code = gs1ai_pkg::AI_00;
			16'h3031: m.code = gs1ai_pkg::AI_01;
			16'h3032: m.code = gs1ai_pkg::AI_02;
			16'h3130: m.code = gs1ai_pkg::AI_10;
			16'h3131: m.code = gs1ai_pkg::AI_11;
			16'h3135: m.code = gs1ai_pkg::AI_15;
			16'h3137: m.code = gs1ai_pkg::AI_17;
			16'h3231: m.code = gs1ai_pkg::AI_21;
			default:  m.hit  = 1'b0;
		endcase
		return m;
	endfunction

	function automatic logic allowed(input logic [2:0] code, input logic [7:0] seen,
			input logic boundary);
		logic ok;
		ok = !seen[code];
		if (code == gs1ai_pkg::AI_00 && seen[gs1ai_pkg::AI_01])
			ok = 1'b0;
		if (code == gs1ai_pkg::AI_02 && !seen[gs1ai_pkg::AI_01])
			ok = 1'b0;
		if (boundary && (code == gs1ai_pkg::AI_00 || code == gs1ai_pkg::AI_02))
			ok = 1'b0;
		return ok;
	endfunction

	function automatic logic [4:0] fixed_len(input logic [2:0] code);
		logic [4:0] len;
		case (code)
			gs1ai_pkg::AI_00:                     len = 5'd18;
			gs1ai_pkg::AI_01, gs1ai_pkg::AI_02:   len = 5'd14;
			gs1ai_pkg::AI_11, gs1ai_pkg::AI_15,
			gs1ai_pkg::AI_17:                     len = 5'd6;
			default:                              len = 5'd0;
		endcase
		return len;
	endfunction

	// Clear per-string state, keep the mode.
	function automatic st_t clear_str(input st_t s);
		st_t r;
		r            = '0;
		r.phase      = PH_AI1;
		r.mode       = s.mode;
		return r;
	endfunction

	function automatic st_t open_fld(input st_t s, input logic [2:0] code);
		st_t r;
		r             = s;
		r.current_ai  = code;
		r.seen        = s.seen | (8'h01 << code);
		if (fixed_len(code) != 5'd0) begin
			r.remaining = fixed_len(code);
			r.phase     = PH_FIXED;
		end else begin
			r.held_first = 1'b1;
			r.held_valid = 1'b0;
			r.phase      = PH_VAR;
		end
		return r;
	endfunction

	function automatic gs1ai_pkg::evt_item_t mk_ev(input logic [1:0] kind,
			input logic [2:0] ai, input logic [7:0] ch, input logic stop, input logic lst);
		gs1ai_pkg::evt_item_t e;
		e.event_kind    = kind;
		e.ai_code       = ai;
		e.value_char    = ch;
		e.stopped_early = stop;
		e.last          = lst;
		return e;
	endfunction

	st_t                  st_q;
	st_t                  s;
	st_t                  nx;
	ai_match_t            pair;
	gs1ai_pkg::evt_item_t cand [gs1ai_pkg::NUM_SLOTS];
	logic [2:0]           cand_v;
	logic [1:0]           k;

	always_comb begin
		s = st_q;
		if (item.first_char) begin
			s      = clear_str(st_q);
			s.mode = item.strict_mode;
		end
		nx     = s;
		cand_v = '0;
		for (int i = 0; i < gs1ai_pkg::NUM_SLOTS; i++)
			cand[i] = '0;
		pair = lookup_ai(s.held_char, item.char_in);

		case (s.phase)
			PH_AI1: begin
				// strict mode skips a separator between fields
				if (!(s.mode && item.char_in == gs1ai_pkg::GS_CHAR)) begin
					nx.held_char  = item.char_in;
					nx.held_valid = 1'b1;
					nx.phase      = PH_AI2;
				end
			end
			PH_AI2: begin
				nx.held_valid = 1'b0;
				nx.held_char  = 8'h00;
				if (!pair.hit || !allowed(pair.code, s.seen, 1'b0)) begin
					nx.halted = 1'b1;
					nx.phase  = PH_DONE;
				end else begin
					nx        = open_fld(nx, pair.code);
					cand_v[0] = 1'b1;
					cand[0]   = mk_ev(gs1ai_pkg::EVK_OPEN, pair.code, 8'h00, 1'b0, 1'b0);
				end
			end
			PH_FIXED: begin
				cand_v[0] = 1'b1;
				cand[0]   = mk_ev(gs1ai_pkg::EVK_VALUE, s.current_ai, item.char_in,
					1'b0, 1'b0);
				if (s.remaining != 5'd0)
					nx.remaining = s.remaining - 5'd1;
				if (nx.remaining == 5'd0)
					nx.phase = PH_AI1;
			end
			PH_VAR: begin
				if (s.mode) begin
					if (item.char_in == gs1ai_pkg::GS_CHAR) begin
						nx.phase = PH_AI1;
					end else begin
						cand_v[0] = 1'b1;
						cand[0]   = mk_ev(gs1ai_pkg::EVK_VALUE, s.current_ai,
							item.char_in, 1'b0, 1'b0);
					end
				end else if (s.held_first) begin
					// first value character is never a boundary candidate
					cand_v[0]     = 1'b1;
					cand[0]       = mk_ev(gs1ai_pkg::EVK_VALUE, s.current_ai,
						item.char_in, 1'b0, 1'b0);
					nx.held_first = 1'b0;
				end else if (!s.held_valid) begin
					nx.held_char  = item.char_in;
					nx.held_valid = 1'b1;
				end else if (pair.hit && allowed(pair.code, s.seen, 1'b1)) begin
					nx.held_valid = 1'b0;
					nx.held_char  = 8'h00;
					nx            = open_fld(nx, pair.code);
					cand_v[0]     = 1'b1;
					cand[0]       = mk_ev(gs1ai_pkg::EVK_OPEN, pair.code, 8'h00,
						1'b0, 1'b0);
				end else begin
					// release the held character, hold the new one
					cand_v[0]    = 1'b1;
					cand[0]      = mk_ev(gs1ai_pkg::EVK_VALUE, s.current_ai,
						s.held_char, 1'b0, 1'b0);
					nx.held_char = item.char_in;
				end
			end
			default: begin
			end
		endcase

		if (item.last_char) begin
			if (nx.phase == PH_AI2)
				nx.halted = 1'b1;
			if (nx.phase == PH_VAR && nx.held_valid) begin
				cand_v[1] = 1'b1;
				cand[1]   = mk_ev(gs1ai_pkg::EVK_VALUE, nx.current_ai, nx.held_char,
					1'b0, 1'b0);
			end
			cand_v[2] = 1'b1;
			cand[2]   = mk_ev(gs1ai_pkg::EVK_END, gs1ai_pkg::AI_00, 8'h00, nx.halted, 1'b1);
			nx        = clear_str(nx);
		end

		// pack the valid events from slot 0 up
		bundle = '0;
		k      = 2'd0;
		for (int i = 0; i < gs1ai_pkg::NUM_SLOTS; i++) begin
			if (cand_v[i]) begin
				bundle.ev[k] = cand[i];
				k            = k + 2'd1;
			end
		end
		bundle.cnt = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clear_str('0);
		end else if (advance) begin
			st_q <= nx;
		end
	end

	`include "gs1_ai_element_splitter_assert.svh"

	`GS1AI_ASSERT_NEXT(a_eos_clears, advance && item.last_char, st_q.phase == PH_AI1 && st_q.seen == 8'h00 && !st_q.halted, "string state not cleared after last character")
	`GS1AI_ASSERT_NEXT(a_mode_sampled, advance && item.first_char, st_q.mode == $past(item.strict_mode), "mode not taken from first character")
	`GS1AI_ASSERT_NOW(a_end_is_last, advance && item.last_char, bundle.cnt != 2'd0 && bundle.ev[bundle.cnt - 2'd1].event_kind == gs1ai_pkg::EVK_END, "last character without end event in final slot")

endmodule

FILE: hw/rtl/gs1ai_evt_buf.sv
// Result register: holds a character's events, drains one per evt_ready cycle.
module gs1ai_evt_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  gs1ai_pkg::evt_bundle_t bundle,
	output logic                   free,
	output logic                   evt_valid,
	input  logic                   evt_ready,
	output gs1ai_pkg::evt_item_t   evt_data
);

	logic                                          valid_q;
	gs1ai_pkg::evt_item_t [gs1ai_pkg::NUM_SLOTS-1:0] ev_q;
	logic [1:0]                                    cnt_q;
	logic [1:0]                                    idx_q;
	logic                                          at_last;

	assign at_last   = (idx_q == cnt_q - 2'd1);
	assign free      = !valid_q || (evt_ready && at_last);
	assign evt_valid = valid_q;
	assign evt_data  = ev_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= 2'd0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= bundle.cnt;
			idx_q   <= 2'd0;
		end else if (valid_q && evt_ready) begin
			if (at_last)
				valid_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			ev_q <= bundle.ev;
	end

	`include "gs1_ai_element_splitter_assert.svh"

	`GS1AI_ASSERT_NOW(a_load_nonempty, load, bundle.cnt != 2'd0 && free, "empty bundle loaded or bundle overwritten")
	`GS1AI_ASSERT_NOW(a_idx_in_range, valid_q, idx_q < cnt_q, "drain index past event count")
	`GS1AI_ASSERT_NOW(a_end_drains_last, valid_q && evt_data.event_kind == gs1ai_pkg::EVK_END, at_last && evt_data.last, "end event not in final slot")

endmodule

FILE: hw/rtl/gs1_ai_element_splitter.sv
// An accepted item passes the input register, then the result register once
// its events fit. Throughput: one character per cycle while each character
// causes at most one event and evt_ready is high; a character causing more
// events (at most 3) holds the input while they drain one per cycle.
// Reset (arst_n low, asynchronous): input and result registers empty, parse
// state back to awaiting an identifier, heuristic mode, nothing seen.
module gs1_ai_element_splitter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_ready,
	input  gs1ai_pkg::char_item_t char_data,
	output logic                  evt_valid,
	input  logic                  evt_ready,
	output gs1ai_pkg::evt_item_t  evt_data
);

	// Input register: parts the scanner side from the parse logic.
	logic                   vld_s1;
	gs1ai_pkg::char_item_t  item_s1;

	// Parse step outputs and handshake between parser and result register.
	gs1ai_pkg::evt_bundle_t bundle;
	logic                   buf_free;
	logic                   advance;
	logic                   buf_load;

	// Advance the held character when its events fit in the result register;
	// a character with no events (identifier digit, held lookahead, skipped
	// separator, halted string) advances regardless.
	assign advance    = vld_s1 && (buf_free || bundle.cnt == 2'd0);
	assign buf_load   = advance && bundle.cnt != 2'd0;
	assign char_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (char_ready) begin
			vld_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready)
			item_s1 <= char_data;
	end

	// Parse state lives here; it updates only when the held character advances.
	gs1ai_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.bundle  (bundle)
	);

	// Result register: drain up to three events per character, in order.
	gs1ai_evt_buf u_evt_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (buf_load),
		.bundle    (bundle),
		.free      (buf_free),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt_data  (evt_data)
	);

endmodule
